[src/bsa_pkg.sv]
package bsa_pkg;

  localparam int MAX_GROUPS_DEF = 64;
  localparam int SLOT_BITS      = 32;
  localparam int SLOT_W         = 5;
  localparam int GROUP_W        = 6;
  localparam int FUNC_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int CFG_W          = 7;
  localparam int TDATA_W        = 16;

  localparam logic [SLOT_BITS-1:0] FULL_MASK = 32'hFFFF_FFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACQUIRE = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_TRIM    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FAILED  = 2'd1,
    ST_IGNORED = 2'd2,
    ST_SPARE   = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the input transfer
    logic decode;    // search, grow, trim, launch mask read
    logic update;    // read-modify-write of one group mask
    logic load_out;  // move result to output register
  } bsa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read;
    logic out_free;
  } bsa_stat_t;

endpackage

[src/bsa_ram.sv]
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bsa_ctrl.sv]
module bsa_ctrl import bsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  bsa_stat_t stat,
  output bsa_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_READ   = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = stat.need_read ? S_READ : S_DONE;
      end
      S_READ: begin
        cmd.update = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[src/bsa_datapath.sv]
module bsa_datapath import bsa_pkg::*; #(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [GROUP_W-1:0]  in_group,
  input  logic [SLOT_W-1:0]   in_slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [GROUP_W-1:0]  out_group,
  output logic [SLOT_W-1:0]   out_slot,
  input  bsa_cmd_t            cmd,
  output bsa_stat_t           stat
);

  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW = $clog2(MAX_GROUPS + 1);

  function automatic logic [CW-1:0] clamp_groups(input logic [CFG_W-1:0] v);
    logic [CW-1:0] n;
    if (v == '0) begin
      n = CW'(1);
    end else if (32'(v) > 32'(MAX_GROUPS)) begin
      n = CW'(MAX_GROUPS);
    end else begin
      n = CW'(v);
    end
    return n;
  endfunction

  // captured item
  func_t              func;
  logic [GROUP_W-1:0] grp;
  logic [SLOT_W-1:0]  slot;

  // per-group flags; a group whose mask is not valid reads as empty
  logic [CW-1:0]         active;
  logic [MAX_GROUPS-1:0] present;
  logic [MAX_GROUPS-1:0] valid;
  logic [MAX_GROUPS-1:0] full;
  logic [MAX_GROUPS-1:0] empty;

  logic [GW-1:0]       tgt;
  logic [STATUS_W-1:0] res_status;
  logic [GROUP_W-1:0]  res_group;
  logic [SLOT_W-1:0]   res_slot;

  logic [MAX_GROUPS-1:0] act_mask;
  logic [GW-1:0]         pick;
  logic                  found;
  logic [CW:0]           grown;
  logic                  grow_ok;
  logic [GW-1:0]         grp_idx;
  logic                  acq_ok;
  logic                  rel_ok;
  logic [GW-1:0]         rd_addr;

  logic [SLOT_BITS-1:0] rd_data;
  logic [SLOT_BITS-1:0] mask;
  logic [SLOT_W-1:0]    free_bit;
  logic                 rel_hit;
  logic [SLOT_BITS-1:0] new_mask;
  logic                 mem_we;

  // ---- decode: first non-full active group, growth and release checks
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
      act_mask[g] = CW'(g) < active;
      if (act_mask[g] && !full[g]) begin
        found = 1'b1;
        pick  = GW'(g);
      end
    end
    grown   = {active, 1'b0};
    grow_ok = (32'(active) < 32'(MAX_GROUPS)) && (32'(grown) <= 32'(MAX_GROUPS));
    grp_idx = GW'(grp);
    acq_ok  = found ? present[pick] : grow_ok;
    rel_ok  = (32'(grp) < 32'(active)) && present[grp_idx];
    rd_addr = found ? pick : GW'(active);
    if (func != FUNC_ACQUIRE) begin
      rd_addr = grp_idx;
    end
    stat.need_read = ((func == FUNC_ACQUIRE) && acq_ok) ||
                     ((func == FUNC_RELEASE) && rel_ok);
    stat.out_free  = !out_valid || out_ready;
  end

  // ---- update: modify the mask read back from the memory
  always_comb begin
    mask     = valid[tgt] ? rd_data : '0;
    free_bit = '0;
    for (int b = SLOT_BITS - 1; b >= 0; b--) begin
      if (!mask[b]) begin
        free_bit = SLOT_W'(b);
      end
    end
    rel_hit = mask[slot];
    if (func == FUNC_ACQUIRE) begin
      new_mask = mask | (SLOT_BITS'(1) << free_bit);
    end else begin
      new_mask = mask & ~(SLOT_BITS'(1) << slot);
    end
    mem_we = cmd.update && ((func == FUNC_ACQUIRE) || rel_hit);
  end

  bsa_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (MAX_GROUPS)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tgt),
    .wdata (new_mask),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      active <= rst ? CW'(1) : clamp_groups(cfg_wr_data);
      for (int g = 0; g < MAX_GROUPS; g++) begin
        present[g] <= rst ? (g == 0) : (CW'(g) < clamp_groups(cfg_wr_data));
      end
      valid <= '0;
      full  <= '0;
      empty <= '1;
    end else if (cmd.decode) begin
      if (func == FUNC_ACQUIRE && !found && grow_ok) begin
        active <= grown[CW-1:0];
        for (int g = 0; g < MAX_GROUPS; g++) begin
          if (!act_mask[g] && (32'(g) < 32'(grown))) begin
            present[g] <= 1'b1;
            valid[g]   <= 1'b0;
            full[g]    <= 1'b0;
            empty[g]   <= 1'b1;
          end
        end
      end
      if (func == FUNC_TRIM) begin
        present <= present & ~(empty & act_mask);
      end
    end else if (mem_we) begin
      valid[tgt] <= 1'b1;
      full[tgt]  <= new_mask == FULL_MASK;
      empty[tgt] <= new_mask == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func <= func_t'(in_func);
      grp  <= in_group;
      slot <= in_slot;
    end
    if (cmd.decode) begin
      tgt       <= rd_addr;
      res_group <= '0;
      res_slot  <= '0;
      unique case (func)
        FUNC_ACQUIRE: res_status <= acq_ok ? ST_DONE : ST_FAILED;
        FUNC_RELEASE: res_status <= rel_ok ? ST_DONE : ST_IGNORED;
        FUNC_TRIM:    res_status <= ST_DONE;
        FUNC_NONE:    res_status <= ST_IGNORED;
        default:      res_status <= ST_IGNORED;
      endcase
    end
    if (cmd.update) begin
      if (func == FUNC_ACQUIRE) begin
        res_group <= GROUP_W'(tgt);
        res_slot  <= free_bit;
      end else if (!rel_hit) begin
        res_status <= ST_IGNORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_group  <= res_group;
      out_slot   <= res_slot;
    end
  end

endmodule

[src/bitmap_slot_allocator.sv]
// Bitmap slot allocator: hands out slots from groups of 32, one in-use mask
// per group held in a small RAM, with present, full and empty flags per group.
// Input stream: s_tuser carries the operation (acquire, release, trim);
// s_tdata carries group and slot of a release. Output stream: one result per
// input transfer; m_tuser carries the status, m_tdata the granted slot.
// The controller steps through decode and search (launching the mask read),
// a read-modify-write of the group mask and the load into the output
// register when a group mask is read and written (acquire that finds room,
// release to a present group in range); the rest (trim, unused code, failed
// acquire, release to a bad group) go from decode straight to the load.
// One item is worked on at a time; s_tready is high only while the controller
// is idle, so a new item is taken only after the last one has been loaded.
// The output register lets a new item be taken while a result waits; if the
// receiver stalls, the next result waits in the datapath and input stalls.
// Reset sets the active group count to 1; a write of cfg_wr_data sets it from
// the register (clamped to 1..MAX_GROUPS). Both mark those groups present and
// treat every mask as empty through per-group valid flags: no clearing pass.
// Configuration is to be written only while idle; the block does not enforce it.
module bitmap_slot_allocator import bsa_pkg::*; #(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,  // initial_groups
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,      // group_index[5:0], slot_index[10:6]
  input  logic [FUNC_W-1:0]  s_tuser,      // func[1:0]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,      // granted_group[5:0], granted_slot[10:6]
  output logic [STATUS_W-1:0] m_tuser      // status[1:0]
);

  bsa_cmd_t            cmd;
  bsa_stat_t           stat;
  logic [GROUP_W-1:0]  out_group;
  logic [SLOT_W-1:0]   out_slot;

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsa_datapath #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_func     (s_tuser),
    .in_group    (s_tdata[GROUP_W-1:0]),
    .in_slot     (s_tdata[GROUP_W+SLOT_W-1:GROUP_W]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (m_tuser),
    .out_group   (out_group),
    .out_slot    (out_slot),
    .cmd         (cmd),
    .stat        (stat)
  );

  assign m_tdata = {{(TDATA_W - GROUP_W - SLOT_W){1'b0}}, out_slot, out_group};

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bsa_pkg::*;

  typedef struct {
    func_t                op;
    logic [GROUP_W-1:0]   grp;
    logic [SLOT_W-1:0]    slot;
  } slot_req_t;

  typedef struct {
    status_t              st;
    logic [GROUP_W-1:0]   grp;
    logic [SLOT_W-1:0]    slot;
  } slot_grant_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata = '0;
  logic [FUNC_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  // predictor state
  logic [SLOT_BITS-1:0] pool_mask [MAX_GROUPS_DEF];
  bit                   pool_live [MAX_GROUPS_DEF];
  int                   pool_active;

  slot_req_t   req_q[$];
  slot_grant_t grant_expect_q[$];
  slot_req_t   req_in;
  slot_req_t   req_out;
  slot_grant_t grant_exp;

  int sent_cnt = 0;
  int accept_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int err_cnt = 0;
  int n_done = 0;
  int n_failed = 0;
  int n_ignored = 0;
  int cfg_writes = 0;

  bitmap_slot_allocator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always #4 clk = ~clk;

  function automatic void reset_pool(logic [CFG_W-1:0] groups);
    if (groups == 0) pool_active = 1;
    else if (groups > MAX_GROUPS_DEF) pool_active = MAX_GROUPS_DEF;
    else pool_active = int'(groups);
    for (int g = 0; g < MAX_GROUPS_DEF; g++) begin
      pool_mask[g] = '0;
      pool_live[g] = (g < pool_active);
    end
  endfunction

  function automatic slot_grant_t predict_grant(slot_req_t r);
    slot_grant_t res;
    int          pick;
    int          old_n;
    int          bsel;
    bit          found;
    res.st = ST_DONE;
    res.grp = '0;
    res.slot = '0;
    pick = 0;
    bsel = 0;
    found = 1'b0;
    case (r.op)
      FUNC_ACQUIRE: begin
        for (int g = 0; g < pool_active; g++)
          if (!found && pool_mask[g] != FULL_MASK) begin
            found = 1'b1;
            pick = g;
          end
        // every active group full: double, unless that passes the maximum
        if (!found) begin
          old_n = pool_active;
          if (2 * old_n > MAX_GROUPS_DEF) begin
            res.st = ST_FAILED;
          end else begin
            for (int g = old_n; g < 2 * old_n; g++) begin
              pool_mask[g] = '0;
              pool_live[g] = 1'b1;
            end
            pool_active = 2 * old_n;
            pick = old_n;
            found = 1'b1;
          end
        end
        if (found) begin
          if (!pool_live[pick]) begin
            res.st = ST_FAILED;
          end else begin
            for (int b = SLOT_BITS - 1; b >= 0; b--)
              if (!pool_mask[pick][b]) bsel = b;
            pool_mask[pick][bsel] = 1'b1;
            res.grp = pick[GROUP_W-1:0];
            res.slot = bsel[SLOT_W-1:0];
          end
        end
      end
      FUNC_RELEASE: begin
        if (r.grp >= pool_active || !pool_live[r.grp] || !pool_mask[r.grp][r.slot])
          res.st = ST_IGNORED;
        else
          pool_mask[r.grp][r.slot] = 1'b0;
      end
      FUNC_TRIM: begin
        for (int g = 0; g < pool_active; g++)
          if (pool_live[g] && pool_mask[g] == '0) pool_live[g] = 1'b0;
      end
      default: begin
        res.st = ST_IGNORED;
      end
    endcase
    return res;
  endfunction

  // predict on every input transfer, check every output transfer
  always @(posedge clk) begin
    if (rst) begin
      reset_pool(CFG_W'(1));
    end else begin
      if (cfg_wr_en) begin
        reset_pool(cfg_wr_data);
        cfg_writes++;
      end
      if (s_tvalid && s_tready) begin
        req_in.op = func_t'(s_tuser);
        req_in.grp = s_tdata[GROUP_W-1:0];
        req_in.slot = s_tdata[GROUP_W+SLOT_W-1:GROUP_W];
        grant_expect_q.push_back(predict_grant(req_in));
        accept_cnt++;
      end
      if (m_tvalid && m_tready) begin
        if (grant_expect_q.size() == 0) begin
          $display("%0t: unexpected result: status %0d tdata %h", $time, m_tuser, m_tdata);
          err_cnt++;
        end else begin
          grant_exp = grant_expect_q.pop_front();
          case (grant_exp.st)
            ST_DONE:   n_done++;
            ST_FAILED: n_failed++;
            default:   n_ignored++;
          endcase
          if (m_tuser !== grant_exp.st ||
              m_tdata !== {{(TDATA_W-GROUP_W-SLOT_W){1'b0}}, grant_exp.slot, grant_exp.grp}) begin
            $display("%0t: mismatch: expected status %0d group %0d slot %0d, got status %0d group %0d slot %0d (tdata %h)",
                     $time, grant_exp.st, grant_exp.grp, grant_exp.slot, m_tuser,
                     m_tdata[GROUP_W-1:0], m_tdata[GROUP_W+SLOT_W-1:GROUP_W], m_tdata);
            err_cnt++;
          end
        end
      end
    end
  end

  // hold the current request until its transfer, then advance
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || accept_cnt == sent_cnt) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          req_out = req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= req_out.op;
          s_tdata <= {{(TDATA_W-GROUP_W-SLOT_W){1'b0}}, req_out.slot, req_out.grp};
          sent_cnt++;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic push_req(input func_t op, input int grp, input int slot);
    slot_req_t r;
    r.op = op;
    r.grp = grp[GROUP_W-1:0];
    r.slot = slot[SLOT_W-1:0];
    req_q.push_back(r);
  endtask

  // wait for every request to go in and every result to come out
  task automatic wait_idle();
    while (req_q.size() != 0 || accept_cnt != sent_cnt || grant_expect_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_groups(input logic [CFG_W-1:0] groups);
    @(negedge clk);
    cfg_wr_data = groups;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // mostly acquires and releases of slots in use; some noise, trims, spare code
  task automatic feed_mix(input int count, input bit acquire_only);
    slot_req_t r;
    int        pick;
    int        g;
    int        s0;
    for (int i = 0; i < count; i++) begin
      while (req_q.size() > 4) @(negedge clk);
      r.grp = GROUP_W'($urandom_range(0, 63));
      r.slot = SLOT_W'($urandom_range(0, 31));
      pick = acquire_only ? 0 : $urandom_range(0, 99);
      if (pick < 52) begin
        r.op = FUNC_ACQUIRE;
      end else if (pick < 92) begin
        r.op = FUNC_RELEASE;
        if (pick < 80) begin
          g = $urandom_range(0, (pool_active > 4 && $urandom_range(0, 1)) ? 3 : pool_active - 1);
          r.grp = g[GROUP_W-1:0];
          s0 = $urandom_range(0, 31);
          for (int k = 0; k < SLOT_BITS; k++)
            if (pool_mask[g][(s0 + k) % SLOT_BITS]) r.slot = SLOT_W'((s0 + k) % SLOT_BITS);
        end
      end else if (pick < 97) begin
        r.op = FUNC_TRIM;
      end else begin
        r.op = FUNC_NONE;
      end
      req_q.push_back(r);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] groups, input int idle, input int stall,
                           input int count, input bit acquire_only);
    write_groups(groups);
    idle_pct = idle;
    stall_pct = stall;
    feed_mix(count, acquire_only);
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // one group after reset: grants, releases, ignored cases, spare code
    push_req(FUNC_ACQUIRE, 63, 31);
    push_req(FUNC_ACQUIRE, 0, 0);
    push_req(FUNC_RELEASE, 0, 1);
    push_req(FUNC_RELEASE, 0, 1);
    push_req(FUNC_RELEASE, 63, 31);
    push_req(FUNC_NONE, 63, 31);
    // sender holds off until the block has answered everything
    wait_idle();
    push_req(FUNC_TRIM, 0, 0);
    push_req(FUNC_RELEASE, 0, 0);
    push_req(FUNC_TRIM, 63, 31);
    // lowest non-full group trimmed: acquire fails, release to it is ignored
    push_req(FUNC_ACQUIRE, 0, 0);
    push_req(FUNC_RELEASE, 0, 0);
    push_req(FUNC_ACQUIRE, 0, 0);
    wait_idle();

    run_phase(CFG_W'(0),   0,  0,  100, 1'b0);
    run_phase(CFG_W'(127), 81, 0,  80,  1'b0);
    run_phase(CFG_W'(5),   0,  81, 80,  1'b0);
    run_phase(CFG_W'(64),  28, 28, 80,  1'b0);
    // fill from one group so that the active count doubles several times
    run_phase(CFG_W'(1),   0,  0,  140, 1'b1);
    idle_pct = 28;
    stall_pct = 28;
    feed_mix(20, 1'b0);
    wait_idle();
    run_phase(CFG_W'(1),   28, 28, 40, 1'b0);

    repeat (10) @(negedge clk);
    $display("Covered %0d requests over %0d group-count settings: %0d completed, %0d failed acquires, %0d ignored",
             accept_cnt, cfg_writes, n_done, n_failed, n_ignored);
    if (err_cnt == 0 && grant_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", grant_expect_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
